>>> rtl/core/ppcexc_pkg.sv
`timescale 1ns / 1ps

package ppcexc_pkg;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] cur_pc;
    logic [31:0] next_address;
    logic        redirect_pending;
    logic [31:0] machine_state;
    logic [31:0] cause_bits;
    logic [31:0] instruction;
    logic [31:0] effective_address;
  } in_t;

  typedef struct packed {
    logic [31:0] save_pc;
    logic [31:0] save_state;
    logic [31:0] new_state;
    logic [31:0] vector;
    logic [31:0] fault_status;
    logic [31:0] fault_address;
    logic        fault_regs_write;
    logic        abort_instruction;
    logic        context_sync;
    logic        unknown_kind;
  } out_t;

  localparam logic [3:0] KIND_RESET   = 4'd0;
  localparam logic [3:0] KIND_MCHECK  = 4'd1;
  localparam logic [3:0] KIND_DSI     = 4'd2;
  localparam logic [3:0] KIND_ISI     = 4'd3;
  localparam logic [3:0] KIND_EXTINT  = 4'd4;
  localparam logic [3:0] KIND_ALIGN   = 4'd5;
  localparam logic [3:0] KIND_PROGRAM = 4'd6;
  localparam logic [3:0] KIND_NOFPU   = 4'd7;
  localparam logic [3:0] KIND_DECR    = 4'd8;
  localparam logic [3:0] KIND_SYSCALL = 4'd9;
  localparam logic [3:0] KIND_TRACE   = 4'd10;

  localparam logic [31:0] SRR1_KEEP = 32'h0000_FF73;
  localparam logic [31:0] MSR_KEEP  = 32'hFFFB_1041;
  localparam logic [31:0] HIGH_VEC  = 32'hFFF0_0000;
  localparam logic [31:0] WORD_MASK = 32'hFFFF_FFFC;
  localparam logic [31:0] VEC_SYSCALL = 32'h0000_0C00;
  localparam logic [31:0] VEC_TRACE   = 32'h0000_0D00;
  localparam int unsigned MSR_LE_BIT  = 0;
  localparam int unsigned MSR_IP_BIT  = 6;
  localparam int unsigned MSR_ILE_BIT = 16;

  localparam logic [31:0] XO_MASK    = 32'hFC00_07FF;
  localparam logic [31:0] DCBZ_MASK  = 32'hFFE0_07FF;
  localparam logic [31:0] DCBZ_OP    = 32'h7C00_07EC;
  localparam logic [31:0] LSWI_OP    = 32'h7C00_04AA;
  localparam logic [31:0] LSWX_OP    = 32'h7C00_042A;
  localparam logic [5:0]  PRIM_X     = 6'd31;
  localparam logic [5:0]  PRIM_LMW   = 6'd46;
  localparam int unsigned N_INDEXED  = 32;

  localparam logic [31:0] INDEXED_OPS [N_INDEXED] = '{
    32'h7c000028, 32'h7c0002aa, 32'h7c00042a, 32'h7c0004aa,
    32'h7c00052a, 32'h7c0005aa, 32'h7c0002ea, 32'h7c00012c,
    32'h7c00042c, 32'h7c00052c, 32'h7c00062c, 32'h7c00072c,
    32'h7c00026c, 32'h7c00036c, 32'h7c00002e, 32'h7c00012e,
    32'h7c00022e, 32'h7c0002ae, 32'h7c00032e, 32'h7c00042e,
    32'h7c0004ae, 32'h7c00052e, 32'h7c0005ae, 32'h7c00006e,
    32'h7c00016e, 32'h7c00026e, 32'h7c0002ee, 32'h7c00036e,
    32'h7c00046e, 32'h7c0004ee, 32'h7c00056e, 32'h7c0005ee
  };

endpackage

>>> rtl/core/ppcexc_dsisr.sv
`timescale 1ns / 1ps

module ppcexc_dsisr (
  input  logic [31:0] ins,
  output logic [31:0] dsisr
);
  import ppcexc_pkg::*;

  logic [5:0]  prim;
  logic [31:0] key;
  logic        indexed;
  logic        dform;

  assign prim = ins[31:26];
  assign key  = ins & XO_MASK;

  always_comb begin
    indexed = ((ins & DCBZ_MASK) == DCBZ_OP);
    for (int i = 0; i < N_INDEXED; i++) begin
      if (INDEXED_OPS[i] == key) begin
        indexed = 1'b1;
      end
    end
  end

  assign dform = prim inside {6'd32, 6'd33, 6'd36, 6'd37, [6'd40:6'd55]};

  always_comb begin
    dsisr = '0;
    if (dform) begin
      dsisr[14]    = ins[26];
      dsisr[13:10] = ins[30:27];
    end else if (prim == PRIM_X && indexed) begin
      dsisr[16:15] = ins[2:1];
      dsisr[14]    = ins[6];
      dsisr[13:10] = ins[10:7];
    end
    dsisr[9:5] = ins[25:21];
    if (prim != PRIM_LMW && key != LSWI_OP && key != LSWX_OP) begin
      dsisr[4:0] = ins[20:16];
    end
  end

endmodule

>>> rtl/core/ppcexc_calc.sv
`timescale 1ns / 1ps

module ppcexc_calc (
  input  ppcexc_pkg::in_t  req,
  output ppcexc_pkg::out_t res
);
  import ppcexc_pkg::*;

  logic [31:0] pcw;
  logic [31:0] pc_next;
  logic [31:0] dsisr;
  logic [31:0] nmsr;
  logic [31:0] vec;
  logic [31:0] srr0;
  logic        is_align;

  ppcexc_dsisr u_dsisr (
    .ins   (req.instruction),
    .dsisr (dsisr)
  );

  assign pcw      = req.cur_pc & WORD_MASK;
  assign pc_next  = pcw + 32'd4;
  assign is_align = (req.kind == KIND_ALIGN);

  always_comb begin
    case (req.kind)
      KIND_ISI: begin
        srr0 = req.redirect_pending ? req.next_address : pcw;
      end
      KIND_EXTINT, KIND_DECR: begin
        srr0 = req.redirect_pending ? req.next_address : pc_next;
      end
      KIND_SYSCALL, KIND_TRACE: begin
        srr0 = pc_next;
      end
      default: begin
        srr0 = pcw;
      end
    endcase
  end

  always_comb begin
    nmsr             = req.machine_state & MSR_KEEP;
    nmsr[MSR_LE_BIT] = nmsr[MSR_ILE_BIT];
    case (req.kind)
      KIND_SYSCALL: vec = VEC_SYSCALL;
      KIND_TRACE:   vec = VEC_TRACE;
      default:      vec = {20'd0, req.kind + 4'd1, 8'd0};
    endcase
    if (nmsr[MSR_IP_BIT]) begin
      vec = vec | HIGH_VEC;
    end
  end

  always_comb begin
    res = '0;
    if (req.kind > KIND_TRACE) begin
      res.unknown_kind = 1'b1;
    end else begin
      res.save_pc           = srr0;
      res.save_state        = (req.machine_state & SRR1_KEEP) |
                              (is_align ? 32'd0 : req.cause_bits);
      res.new_state         = nmsr;
      res.vector            = vec;
      res.fault_status      = is_align ? dsisr : 32'd0;
      res.fault_address     = is_align ? req.effective_address : 32'd0;
      res.fault_regs_write  = is_align;
      res.abort_instruction = (req.kind != KIND_EXTINT) && (req.kind != KIND_DECR);
      res.context_sync      = (req.kind != KIND_RESET) && (req.kind != KIND_MCHECK);
    end
  end

endmodule

>>> rtl/core/powerpc_exception_entry.sv
// Data goes from the input register through the calculation into the result register.
// Throughput: one transaction per cycle while out_ready stays high; both the input register
// and the result register advance whenever the result register is empty or being taken.
// Reset: synchronous active-low rst_n clears both valid flags; payload registers are not reset.
`timescale 1ns / 1ps

module powerpc_exception_entry (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ppcexc_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ppcexc_pkg::out_t  out_data
);
  import ppcexc_pkg::*;

  logic s1_valid_r;
  logic s1_valid_nxt;
  in_t  s1_data_r;
  logic out_valid_r;
  logic out_valid_nxt;
  out_t out_data_r;
  out_t res;
  logic out_free;

  ppcexc_calc u_calc (
    .req (s1_data_r),
    .res (res)
  );

  assign out_free      = !out_valid_r || out_ready;
  assign in_ready      = !s1_valid_r || out_free;
  assign s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
  assign out_valid_nxt = out_free ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_valid_r && out_free) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/ppcexc_checker.sv
`timescale 1ns / 1ps

module ppcexc_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input ppcexc_pkg::out_t out_data
);
  import ppcexc_pkg::*;

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result transaction changed.");

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.unknown_kind |->
      out_data.save_pc == 32'd0 && out_data.vector == 32'd0 &&
      out_data.new_state == 32'd0 && !out_data.fault_regs_write &&
      !out_data.abort_instruction && !out_data.context_sync)
    else $error("Unknown kind result carries nonzero fields.");

  a_fault_regs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.fault_regs_write |->
      out_data.fault_status == 32'd0 && out_data.fault_address == 32'd0)
    else $error("Fault registers set without a write.");

  a_vector_msr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.unknown_kind |->
      out_data.vector[7:0] == 8'd0 &&
      (out_data.vector[31:20] == 12'hFFF) == out_data.new_state[MSR_IP_BIT] &&
      out_data.new_state[MSR_LE_BIT] == out_data.new_state[MSR_ILE_BIT])
    else $error("Vector or new machine state inconsistent.");

endmodule

bind powerpc_exception_entry ppcexc_checker u_ppcexc_checker (.*);
